@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define GSS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gss assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define GSS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gss assertion failed");

`endif

@@ rtl/gss_pkg.sv @@
// Shared types and constants of the green spill suppressor.
package gss_pkg;

	localparam int NSTG = 11;

	localparam logic [8:0] GAIN_SAT   = 9'd77;
	localparam logic [8:0] GAIN_GREEN = 9'd218;
	localparam logic [8:0] GAIN_BOOST = 9'd276;

	localparam logic [7:0] HUE_MIN_RST = 8'd35;
	localparam logic [7:0] HUE_MAX_RST = 8'd85;

	localparam logic REG_HUE_MIN = 1'b0;
	localparam logic REG_HUE_MAX = 1'b1;

	typedef struct packed {
		logic [7:0] pixel_blue;
		logic [7:0] pixel_green;
		logic [7:0] pixel_red;
		logic       person_mask;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic       spill_applied;
	} pix_out_t;

	typedef struct packed {
		logic [7:0] v;
		logic [7:0] s;
		logic [7:0] h;
		logic       mask;
	} hsv_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       spill;
	} rgb_t;

	typedef struct packed {
		logic [NSTG:1] adv;
	} pipe_ctl_t;

endpackage

@@ rtl/gss_ctl.sv @@
// Valid bits and per-stage advance chain of the pixel pipeline.
module gss_ctl import gss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_stall,
	output pipe_ctl_t ctl,
	output logic      in_stall,
	output logic      out_valid
);

	logic [NSTG:1]   valid_q;
	logic [NSTG:1]   feed;
	logic [NSTG+1:1] go;

	// a stage loads when it is empty or its successor loads
	always_comb begin
		go[NSTG+1] = !out_stall;
		for (int k = NSTG; k >= 1; k--) begin
			go[k] = !valid_q[k] || go[k+1];
		end
	end

	assign feed = {valid_q[NSTG-1:1], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int k = 1; k <= NSTG; k++) begin
				if (go[k]) begin
					valid_q[k] <= feed[k];
				end
			end
		end
	end

	assign ctl.adv   = go[NSTG:1];
	assign in_stall  = !go[1];
	assign out_valid = valid_q[NSTG];

endmodule

@@ rtl/gss_hsv.sv @@
// Forward color conversion: max/min stage and two pipelined dividers.
module gss_hsv import gss_pkg::*; (
	input  logic       clk,
	input  logic [5:1] adv,
	input  pix_in_t    pix,
	output hsv_t       hsv
);

	typedef struct packed {
		logic [15:0] rem;
		logic [7:0]  den;
		logic [7:0]  quo;
	} div_t;

	// two restoring quotient bits, at bit positions sh+1 and sh
	function automatic div_t div_step(div_t x, logic [2:0] sh);
		div_t        y;
		logic [15:0] dd;
		logic [2:0]  hi;
		y  = x;
		hi = sh + 3'd1;
		dd = {8'b0, y.den} << hi;
		if (y.rem >= dd) begin
			y.rem     = y.rem - dd;
			y.quo[hi] = 1'b1;
		end
		dd = {8'b0, y.den} << sh;
		if (y.rem >= dd) begin
			y.rem     = y.rem - dd;
			y.quo[sh] = 1'b1;
		end
		return y;
	endfunction

	div_t       hdiv_s [1:5];
	div_t       sdiv_s [1:5];
	logic [7:0] v_s    [1:5];
	logic       mask_s [1:5];

	logic [7:0]         vmax, vmin, d;
	logic signed [17:0] rs, gs, bs, ds, t;
	logic [15:0]        hnum, snum;
	div_t               hin, sin;

	always_comb begin
		vmax = pix.pixel_red;
		vmin = pix.pixel_red;
		if (pix.pixel_green > vmax) vmax = pix.pixel_green;
		if (pix.pixel_blue  > vmax) vmax = pix.pixel_blue;
		if (pix.pixel_green < vmin) vmin = pix.pixel_green;
		if (pix.pixel_blue  < vmin) vmin = pix.pixel_blue;
		d  = vmax - vmin;
		rs = $signed({10'b0, pix.pixel_red});
		gs = $signed({10'b0, pix.pixel_green});
		bs = $signed({10'b0, pix.pixel_blue});
		ds = $signed({10'b0, d});
		// hue numerator scaled by d, priority red, green, blue
		if (vmax == pix.pixel_red) begin
			t = 18'sd30 * (gs - bs);
		end else if (vmax == pix.pixel_green) begin
			t = 18'sd60 * ds + 18'sd30 * (bs - rs);
		end else begin
			t = 18'sd120 * ds + 18'sd30 * (rs - gs);
		end
		if (t[17]) begin
			t = t + 18'sd180 * ds;
		end
		hnum = t[15:0] + {9'b0, d[7:1]};
		snum = {d, 8'b0} - {8'b0, d} + {9'b0, vmax[7:1]};
		hin  = '{rem: hnum, den: d, quo: 8'd0};
		sin  = '{rem: snum, den: vmax, quo: 8'd0};
		// force a zero quotient where the divisor would be zero
		if (d == 8'd0) begin
			hin.rem = 16'd0;
			hin.den = 8'd1;
		end
		if (vmax == 8'd0) begin
			sin.rem = 16'd0;
			sin.den = 8'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			hdiv_s[1] <= hin;
			sdiv_s[1] <= sin;
			v_s[1]    <= vmax;
			mask_s[1] <= pix.person_mask;
		end
	end

	for (genvar k = 2; k <= 5; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv[k]) begin
				hdiv_s[k] <= div_step(hdiv_s[k-1], 3'(10 - 2 * k));
				sdiv_s[k] <= div_step(sdiv_s[k-1], 3'(10 - 2 * k));
				v_s[k]    <= v_s[k-1];
				mask_s[k] <= mask_s[k-1];
			end
		end
	end

	assign hsv.v    = v_s[5];
	assign hsv.s    = sdiv_s[5].quo;
	assign hsv.h    = hdiv_s[5].quo;
	assign hsv.mask = mask_s[5];

endmodule

@@ rtl/gss_back.sv @@
// Spill decision, saturation gain and back conversion to BGR.
module gss_back import gss_pkg::*; (
	input  logic        clk,
	input  logic [10:6] adv,
	input  hsv_t        hsv,
	input  logic [7:0]  hue_min,
	input  logic [7:0]  hue_max,
	output rgb_t        rgb
);

	// stage 6
	logic [7:0]  hw, ssc;
	logic [16:0] sm;
	logic        spill;
	logic [2:0]  sec;
	logic [7:0]  fw;

	logic [7:0] v_s6, s_s6;
	logic [2:0] sec_s6;
	logic [4:0] f_s6;
	logic       spill_s6;

	always_comb begin
		hw    = (hsv.h >= 8'd180) ? hsv.h - 8'd180 : hsv.h;
		spill = hsv.mask && (hw > hue_min) && (hw <= hue_max);
		sm    = {9'b0, hsv.s} * {8'b0, GAIN_SAT} + 17'd128;
		ssc   = spill ? sm[15:8] : hsv.s;
		if (hw >= 8'd150)      sec = 3'd5;
		else if (hw >= 8'd120) sec = 3'd4;
		else if (hw >= 8'd90)  sec = 3'd3;
		else if (hw >= 8'd60)  sec = 3'd2;
		else if (hw >= 8'd30)  sec = 3'd1;
		else                   sec = 3'd0;
		fw = hw - {sec, 5'b0} + {4'b0, sec, 1'b0};
	end

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			v_s6     <= hsv.v;
			s_s6     <= ssc;
			sec_s6   <= sec;
			f_s6     <= fw[4:0];
			spill_s6 <= spill;
		end
	end

	// stage 7
	logic [12:0] sf, sg;
	logic [4:0]  fm;
	logic [7:0]  v_s7, c_s7;
	logic [12:0] a_s7, b_s7;
	logic [2:0]  sec_s7;
	logic        spill_s7;

	always_comb begin
		fm = 5'd30 - f_s6;
		sf = {5'b0, s_s6} * {8'b0, f_s6};
		sg = {5'b0, s_s6} * {8'b0, fm};
	end

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			v_s7     <= v_s6;
			c_s7     <= 8'd255 - s_s6;
			a_s7     <= 13'd7650 - sf;
			b_s7     <= 13'd7650 - sg;
			sec_s7   <= sec_s6;
			spill_s7 <= spill_s6;
		end
	end

	// stage 8
	logic [15:0] np_s8;
	logic [20:0] nq_s8, nt_s8;
	logic [7:0]  v_s8;
	logic [2:0]  sec_s8;
	logic        spill_s8;

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			np_s8    <= {8'b0, v_s7} * {8'b0, c_s7} + 16'd127;
			nq_s8    <= {13'b0, v_s7} * {8'b0, a_s7} + 21'd3825;
			nt_s8    <= {13'b0, v_s7} * {8'b0, b_s7} + 21'd3825;
			v_s8     <= v_s7;
			sec_s8   <= sec_s7;
			spill_s8 <= spill_s7;
		end
	end

	// stage 9: reciprocal estimate, low by at most one
	logic [24:0] pp;
	logic [29:0] pq, pt;
	logic [15:0] np_s9;
	logic [20:0] nq_s9, nt_s9;
	logic [7:0]  qp_s9, qq_s9, qt_s9, v_s9;
	logic [2:0]  sec_s9;
	logic        spill_s9;

	always_comb begin
		pp = {9'b0, np_s8} * 25'd257;
		pq = {9'b0, nq_s8} * 30'd274;
		pt = {9'b0, nt_s8} * 30'd274;
	end

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			np_s9    <= np_s8;
			nq_s9    <= nq_s8;
			nt_s9    <= nt_s8;
			qp_s9    <= pp[23:16];
			qq_s9    <= pq[28:21];
			qt_s9    <= pt[28:21];
			v_s9     <= v_s8;
			sec_s9   <= sec_s8;
			spill_s9 <= spill_s8;
		end
	end

	// stage 10: correct the estimate and pick the sector's channel order
	logic [15:0] rp;
	logic [20:0] rq, rt;
	logic [7:0]  p, q, tt;
	rgb_t        sel;

	always_comb begin
		rp = np_s9 - ({qp_s9, 8'b0} - {8'b0, qp_s9});
		rq = nq_s9 - {13'b0, qq_s9} * 21'd7650;
		rt = nt_s9 - {13'b0, qt_s9} * 21'd7650;
		p  = (rp >= 16'd255)  ? qp_s9 + 8'd1 : qp_s9;
		q  = (rq >= 21'd7650) ? qq_s9 + 8'd1 : qq_s9;
		tt = (rt >= 21'd7650) ? qt_s9 + 8'd1 : qt_s9;
		sel.spill = spill_s9;
		case (sec_s9)
			3'd0: begin sel.blue = p;    sel.green = tt;   sel.red = v_s9; end
			3'd1: begin sel.blue = p;    sel.green = v_s9; sel.red = q;    end
			3'd2: begin sel.blue = tt;   sel.green = v_s9; sel.red = p;    end
			3'd3: begin sel.blue = v_s9; sel.green = q;    sel.red = p;    end
			3'd4: begin sel.blue = v_s9; sel.green = p;    sel.red = tt;   end
			default: begin sel.blue = q; sel.green = p;    sel.red = v_s9; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			rgb <= sel;
		end
	end

endmodule

@@ rtl/gss_gain.sv @@
// Spill color gains with saturation, feeding the output register.
module gss_gain import gss_pkg::*; (
	input  logic     clk,
	input  logic     adv,
	input  rgb_t     rgb,
	output pix_out_t res
);

	function automatic logic [7:0] scale(logic [7:0] x, logic [8:0] g);
		logic [16:0] pr;
		pr = {9'b0, x} * {8'b0, g} + 17'd128;
		return pr[16] ? 8'd255 : pr[15:8];
	endfunction

	pix_out_t nxt;

	always_comb begin
		nxt.spill_applied = rgb.spill;
		if (rgb.spill) begin
			nxt.out_blue  = scale(rgb.blue, GAIN_BOOST);
			nxt.out_green = scale(rgb.green, GAIN_GREEN);
			nxt.out_red   = scale(rgb.red, GAIN_BOOST);
		end else begin
			nxt.out_blue  = rgb.blue;
			nxt.out_green = rgb.green;
			nxt.out_red   = rgb.red;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res <= nxt;
		end
	end

endmodule

@@ rtl/green_spill_suppressor.sv @@
// Top level of the green spill suppressor: register port and pixel pipeline.
//
//   channel   direction  handshake                payload
//   pixel     in         pixel_valid/pixel_stall   pix_in_t  (B, G, R, person mask)
//   result    out        result_valid/result_stall pix_out_t (B, G, R, spill flag)
//   config    in         APB psel/penable/pwrite   hue_min at 0x0, hue_max at 0x4
//
// One pixel per clock is accepted while pixel_stall is low; each passes 11 register
// stages on its way to result: one max/min stage, the two 4-stage radix-4
// dividers for hue and saturation, the 5-stage back conversion with its
// reciprocal multiplies and the gain stage that feeds the output register.
// Reset clears the valid bits and loads hue_min = 35, hue_max = 85.
// A stall on the result side freezes only full stages: empty stages still
// fill, so pixel_stall rises only once every stage holds a transaction.
module green_spill_suppressor import gss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input pixels
	input  logic        pixel_valid,
	output logic        pixel_stall,
	input  pix_in_t     pixel,
	// results
	output logic        result_valid,
	input  logic        result_stall,
	output pix_out_t    result
);

	logic [7:0] hue_min_q, hue_max_q;
	pipe_ctl_t  ctl;
	hsv_t       hsv;
	rgb_t       rgb;

	// register file: word index in paddr[2], low bits ignored
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_min_q <= HUE_MIN_RST;
			hue_max_q <= HUE_MAX_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_HUE_MIN: hue_min_q <= pwdata[7:0];
				REG_HUE_MAX: hue_max_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_HUE_MIN: prdata = {24'b0, hue_min_q};
			REG_HUE_MAX: prdata = {24'b0, hue_max_q};
			default:     prdata = 32'b0;
		endcase
	end

	// valid bits and advance chain for all stages
	gss_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel_valid),
		.out_stall (result_stall),
		.ctl       (ctl),
		.in_stall  (pixel_stall),
		.out_valid (result_valid)
	);

	// stages 1-5: max/min, hue and saturation division
	gss_hsv u_hsv (
		.clk (clk),
		.adv (ctl.adv[5:1]),
		.pix (pixel),
		.hsv (hsv)
	);

	// stages 6-10: spill test, saturation gain, back to BGR
	gss_back u_back (
		.clk     (clk),
		.adv     (ctl.adv[10:6]),
		.hsv     (hsv),
		.hue_min (hue_min_q),
		.hue_max (hue_max_q),
		.rgb     (rgb)
	);

	// stage 11: channel gains into the output register
	gss_gain u_gain (
		.clk (clk),
		.adv (ctl.adv[11]),
		.rgb (rgb),
		.res (result)
	);

endmodule

@@ rtl/gss_chk.sv @@
// Port-level checker for the green spill suppressor, bound to the top level.
`include "assert_macros.svh"

module gss_chk import gss_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     pixel_stall,
	input logic     result_valid,
	input logic     result_stall,
	input pix_out_t result
);

	// hold a stalled result transaction
	`GSS_ASSERT_NXT(a_hold, result_valid && result_stall, result_valid && $stable(result))

	// stall the input only with a full pipeline behind a stalled result
	`GSS_ASSERT_IMP(a_backpressure, pixel_stall, result_valid && result_stall)

	// green gain never lets a spill pixel reach full green
	`GSS_ASSERT_IMP(a_green_gain, result_valid && result.spill_applied,
		result.out_green <= 8'd217)

endmodule

bind green_spill_suppressor gss_chk u_gss_chk (.*);

@@ tb/tb.sv @@
// Testbench for the green spill suppressor: random pixel stream checked against a local predictor.
module tb;
	import gss_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        pixel_valid;
	logic        pixel_stall;
	pix_in_t     pixel;
	logic        result_valid;
	logic        result_stall;
	pix_out_t    result;

	green_spill_suppressor DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	// Local copy of the hue window, updated only when a register write lands.
	logic [7:0] win_lo;
	logic [7:0] win_hi;

	pix_in_t  pending_pixels[$];
	pix_out_t expected_pixels[$];
	int       fail_count;
	bit       feed_enable;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Round-to-nearest divide, ties up.
	function automatic int unsigned div_round(int unsigned n, int unsigned d);
		return (n + d / 2) / d;
	endfunction

	// Q1.8 gain with rounding, clipped to 255.
	function automatic int unsigned apply_gain(int unsigned x, int unsigned g);
		int unsigned y;
		y = (x * g + 128) >> 8;
		return (y > 255) ? 255 : y;
	endfunction

	// Predict the corrected pixel for one incoming transaction.
	function automatic pix_out_t correct_pixel(pix_in_t px, logic [7:0] lo, logic [7:0] hi);
		int b, g, r, vmax, vmin, d, base, num, tt;
		int unsigned v, s, h, sec, f, p, q, t, ob, og, orr;
		bit spill;
		pix_out_t o;
		b = int'(px.pixel_blue);
		g = int'(px.pixel_green);
		r = int'(px.pixel_red);
		vmax = r; vmin = r;
		if (g > vmax) vmax = g;
		if (b > vmax) vmax = b;
		if (g < vmin) vmin = g;
		if (b < vmin) vmin = b;
		d = vmax - vmin;
		v = vmax;
		s = 0;
		h = 0;
		if (v != 0) s = div_round(255 * d, v);
		if (d != 0) begin
			// priority: red, then green, then blue
			if (vmax == r) begin
				base = 0; num = g - b;
			end else if (vmax == g) begin
				base = 60; num = b - r;
			end else begin
				base = 120; num = r - g;
			end
			tt = base * d + 30 * num;
			if (tt < 0) tt += 180 * d;
			h = div_round(tt, d);
			if (h >= 180) h -= 180;
		end
		spill = px.person_mask && (h > lo) && (h <= hi);
		if (spill) s = apply_gain(s, 32'(GAIN_SAT));
		sec = h / 30;
		f = h % 30;
		p = div_round(v * (255 - s), 255);
		q = div_round(v * (7650 - s * f), 7650);
		t = div_round(v * (7650 - s * (30 - f)), 7650);
		case (sec)
			0: begin ob = p; og = t; orr = v; end
			1: begin ob = p; og = v; orr = q; end
			2: begin ob = t; og = v; orr = p; end
			3: begin ob = v; og = q; orr = p; end
			4: begin ob = v; og = p; orr = t; end
			default: begin ob = q; og = p; orr = v; end
		endcase
		if (spill) begin
			og = apply_gain(og, 32'(GAIN_GREEN));
			ob = apply_gain(ob, 32'(GAIN_BOOST));
			orr = apply_gain(orr, 32'(GAIN_BOOST));
		end
		o.out_blue = ob[7:0];
		o.out_green = og[7:0];
		o.out_red = orr[7:0];
		o.spill_applied = spill;
		return o;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 60) return 0;
		if (k < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Driver: present the next pending pixel, hold it while stalled.
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid <= 1'b0;
			pixel <= '0;
			send_gap <= 0;
		end else begin
			if (pixel_valid && !pixel_stall) begin
				expected_pixels.insert(expected_pixels.size(),
					correct_pixel(pixel, win_lo, win_hi));
			end
			if (!pixel_valid || !pixel_stall) begin
				if (send_gap > 0) begin
					pixel_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (feed_enable && pending_pixels.size() > 0) begin
					pixel <= pending_pixels.pop_front();
					pixel_valid <= 1'b1;
					send_gap <= gap_len();
				end else begin
					pixel_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted result with the oldest prediction.
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_pixels.size() == 0) begin
					$error("unexpected result transaction");
					fail_count++;
				end else begin
					pix_out_t e;
					e = expected_pixels.pop_front();
					if (result.out_blue !== e.out_blue) begin
						$error("out_blue expected %0d actual %0d", e.out_blue, result.out_blue);
						fail_count++;
					end
					if (result.out_green !== e.out_green) begin
						$error("out_green expected %0d actual %0d", e.out_green, result.out_green);
						fail_count++;
					end
					if (result.out_red !== e.out_red) begin
						$error("out_red expected %0d actual %0d", e.out_red, result.out_red);
						fail_count++;
					end
					if (result.spill_applied !== e.spill_applied) begin
						$error("spill_applied expected %0d actual %0d",
							e.spill_applied, result.spill_applied);
						fail_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				result_stall <= 1'b1;
			end else begin
				stall_left <= gap_len();
				result_stall <= 1'b0;
			end
		end
	end

	// Queue one pixel for the driver.
	task automatic add_pixel(pix_in_t px);
		pending_pixels.insert(pending_pixels.size(), px);
	endtask

	// Register write: setup cycle then access cycle.
	task automatic write_reg(logic addr_sel, logic [7:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {addr_sel, 2'b00};
		pwdata <= {24'($urandom_range(0, 16777215)), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr_sel == REG_HUE_MIN) win_lo = val;
		else win_hi = val;
	endtask

	// Release queued pixels, then drain and let the pipe settle.
	task automatic run_phase();
		feed_enable = 1'b1;
		while (pending_pixels.size() > 0 || pixel_valid || expected_pixels.size() > 0)
			@(posedge clk);
		feed_enable = 1'b0;
		repeat (3 * NSTG) @(posedge clk);
	endtask

	function automatic pix_in_t rand_pixel();
		pix_in_t px;
		px = 25'($urandom);
		return px;
	endfunction

	// Green-leaning pixel so many land inside the spill window.
	function automatic pix_in_t greenish_pixel();
		pix_in_t px;
		px.pixel_green = 8'($urandom_range(64, 255));
		px.pixel_blue = 8'($urandom_range(0, px.pixel_green));
		px.pixel_red = 8'($urandom_range(0, px.pixel_green));
		px.person_mask = ($urandom_range(0, 9) < 8);
		return px;
	endfunction

	initial begin
		logic [7:0] lo_set[6] = '{8'd35, 8'd0, 8'd0, 8'd179, 8'd90, 8'd255};
		logic [7:0] hi_set[6] = '{8'd85, 8'd179, 8'd255, 8'd255, 8'd40, 8'd255};
		pix_in_t px;
		fail_count = 0;
		feed_enable = 1'b0;
		win_lo = HUE_MIN_RST;
		win_hi = HUE_MAX_RST;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: grays, pure primaries, extremes, mask on and off.
		add_pixel('{8'd0, 8'd0, 8'd0, 1'b1});
		add_pixel('{8'd255, 8'd255, 8'd255, 1'b1});
		add_pixel('{8'd128, 8'd128, 8'd128, 1'b0});
		add_pixel('{8'd0, 8'd255, 8'd0, 1'b1});
		add_pixel('{8'd0, 8'd255, 8'd0, 1'b0});
		add_pixel('{8'd255, 8'd0, 8'd0, 1'b1});
		add_pixel('{8'd0, 8'd0, 8'd255, 1'b1});
		add_pixel('{8'd255, 8'd0, 8'd255, 1'b1});
		add_pixel('{8'd0, 8'd255, 8'd255, 1'b1});
		add_pixel('{8'd255, 8'd255, 8'd0, 1'b1});
		add_pixel('{8'd40, 8'd200, 8'd60, 1'b1});
		add_pixel('{8'd1, 8'd0, 8'd255, 1'b1});
		add_pixel('{8'd0, 8'd1, 8'd0, 1'b1});
		add_pixel('{8'd200, 8'd250, 8'd10, 1'b1});
		run_phase();

		// Random phases across hue windows, extremes and empty ranges included.
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_HUE_MIN, lo_set[ph]);
			write_reg(REG_HUE_MAX, hi_set[ph]);
			for (int i = 0; i < 130; i++) begin
				if ($urandom_range(0, 1)) px = greenish_pixel();
				else px = rand_pixel();
				add_pixel(px);
			end
			run_phase();
		end

		if (fail_count == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	// Run guard.
	initial begin
		#2000000;
		$display("tb failed");
		$finish;
	end

endmodule
